>>> design/bounded_edit_distance_assert.svh
// Assertion macros for the bounded edit distance block.
`ifndef BOUNDED_EDIT_DISTANCE_ASSERT_SVH
`define BOUNDED_EDIT_DISTANCE_ASSERT_SVH

`ifndef ASSERT_OFF
// Property must hold whenever the antecedent is true (same cycle).
`define BED_ASSERT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Property must hold in the cycle after the antecedent.
`define BED_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define BED_ASSERT(name, clk, rst_n, ante, cons, msg)
`define BED_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif

`endif

>>> design/bed_pkg.sv
// Shared constants for the bounded edit distance block.
`timescale 1ns / 1ps

package bed_pkg;

  // Default number of stored characters per string
  localparam int unsigned MaxLenDefault = 32;
  // Length difference above which the pair is cut short
  localparam int unsigned LenGapLimit   = 3;
  // Distance reported for a cut pair
  localparam int unsigned CutDistance   = 4;
  // Output field width and its saturation value
  localparam int unsigned DistWidth     = 6;
  localparam int unsigned DistMax       = 63;
  localparam int unsigned CharWidth     = 8;
  // Cost / length width for the default string limit
  localparam int unsigned CostWidthDefault = $clog2(MaxLenDefault + 2);

endpackage

>>> design/bed_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bed_ram #(
  parameter int unsigned Width     = 8,
  parameter int unsigned Depth     = 32,
  parameter int unsigned AddrWidth = $clog2(Depth)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AddrWidth-1:0] waddr_i,
  input  logic [Width-1:0]     wdata_i,
  input  logic [AddrWidth-1:0] raddr_i,
  output logic [Width-1:0]     rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/bed_cell.sv
// Shared cell unit: one dynamic-programming cell, minimum of three costs.
`timescale 1ns / 1ps

module bed_cell #(
  parameter int unsigned CostWidth = bed_pkg::CostWidthDefault
) (
  input  logic [bed_pkg::CharWidth-1:0] a_char_i,
  input  logic [bed_pkg::CharWidth-1:0] b_char_i,
  input  logic [CostWidth-1:0]          diag_i,
  input  logic [CostWidth-1:0]          above_i,
  input  logic [CostWidth-1:0]          left_i,
  output logic [CostWidth-1:0]          cost_o
);

  logic [CostWidth-1:0] subst;
  logic [CostWidth-1:0] del;
  logic [CostWidth-1:0] ins;
  logic [CostWidth-1:0] m1;

  // substitution, deletion, insertion; values stay within MaxLen+1
  assign subst = diag_i + CostWidth'(a_char_i != b_char_i);
  assign del   = above_i + CostWidth'(1);
  assign ins   = left_i + CostWidth'(1);
  assign m1    = (subst < del) ? subst : del;
  assign cost_o = (m1 < ins) ? m1 : ins;

endmodule

>>> design/bounded_edit_distance.sv
// Top level: character loading, length check and cell sequencer.
`timescale 1ns / 1ps

// Bounded edit distance. Characters of two byte strings arrive one per item;
// the item with pair_done set ends the pair and produces one result: the
// Levenshtein distance, or 4 with cut_short set when a string exceeds MaxLen
// characters or the lengths differ by more than 3. An item that does not end
// a pair leaves the input unstalled. A pair end goes through the length
// check and then to delivery when cut or when a string is empty; otherwise
// one cell unit evaluates one matrix cell per cycle, reading one entry of
// the cost-row RAM per cycle, with a row-start state before each row of the
// first string. Input is stalled from the pair end until the result is
// loaded into the output register; the output register holds a result while
// the next pair loads.

`include "bounded_edit_distance_assert.svh"

module bounded_edit_distance #(
  parameter int unsigned MaxLen = bed_pkg::MaxLenDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [bed_pkg::CharWidth-1:0]  text_char_i,
  input  logic                           second_string_i,
  input  logic                           pair_done_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bed_pkg::DistWidth-1:0]  distance_o,
  output logic                           cut_short_o
);

  localparam int unsigned LW  = $clog2(MaxLen + 2);  // lengths and costs
  localparam int unsigned AW  = $clog2(MaxLen);      // character address
  localparam int unsigned CAW = $clog2(MaxLen + 1);  // cost-row address
  localparam int unsigned WW  = (LW > bed_pkg::DistWidth) ? LW : bed_pkg::DistWidth;
  localparam int unsigned CW  = bed_pkg::CharWidth;

  typedef enum logic [4:0] {
    StIdle    = 5'b00001,
    StCheck   = 5'b00010,
    StRow     = 5'b00100,
    StCell    = 5'b01000,
    StDeliver = 5'b10000
  } state_e;

  state_e                     state_q, state_d;
  logic [LW-1:0]              first_len_q, first_len_d;
  logic [LW-1:0]              second_len_q, second_len_d;
  logic [LW-1:0]              i_q, i_d;
  logic [LW-1:0]              j_q, j_d;
  logic [LW-1:0]              diag_q, diag_d;
  logic [LW-1:0]              left_q, left_d;
  logic [LW-1:0]              res_q, res_d;
  logic                       cut_q, cut_d;
  logic                       out_valid_q, out_valid_d;
  logic [bed_pkg::DistWidth-1:0] dist_q, dist_d;
  logic                       cut_out_q, cut_out_d;

  logic          in_fire;
  logic          first_we, second_we, cost_we;
  logic [AW-1:0] first_waddr, second_waddr, first_raddr, second_raddr;
  logic [CAW-1:0] cost_waddr, cost_raddr;
  logic [CW-1:0] first_rdata, second_rdata;
  logic [LW-1:0] cost_rdata, above, cell_cost;
  logic [LW-1:0] gap;
  logic          last_col, len_cut;
  logic [WW-1:0] res_wide;

  assign in_stall_o = (state_q != StIdle);
  assign in_fire    = in_valid_i && !in_stall_o;
  assign last_col   = (j_q == second_len_q);

  // character stores
  assign first_we     = in_fire && (text_char_i != '0) && !second_string_i &&
                        (first_len_q < LW'(MaxLen));
  assign second_we    = in_fire && (text_char_i != '0) && second_string_i &&
                        (second_len_q < LW'(MaxLen));
  assign first_waddr  = AW'(first_len_q);
  assign second_waddr = AW'(second_len_q);

  // row char held at i-1; column char and cost entry run one ahead of j
  always_comb begin
    first_raddr  = AW'(i_q - LW'(1));
    second_raddr = '0;
    cost_raddr   = CAW'(1);
    if (state_q == StCell) begin
      second_raddr = last_col ? '0 : AW'(j_q);
      cost_raddr   = last_col ? '0 : CAW'(j_q + LW'(1));
    end
  end

  assign cost_we    = (state_q == StCell);
  assign cost_waddr = CAW'(j_q);

  bed_ram #(.Width(CW), .Depth(MaxLen)) u_first_ram (
    .clk_i  (clk_i),
    .we_i   (first_we),
    .waddr_i(first_waddr),
    .wdata_i(text_char_i),
    .raddr_i(first_raddr),
    .rdata_o(first_rdata)
  );

  bed_ram #(.Width(CW), .Depth(MaxLen)) u_second_ram (
    .clk_i  (clk_i),
    .we_i   (second_we),
    .waddr_i(second_waddr),
    .wdata_i(text_char_i),
    .raddr_i(second_raddr),
    .rdata_o(second_rdata)
  );

  bed_ram #(.Width(LW), .Depth(MaxLen + 1)) u_cost_ram (
    .clk_i  (clk_i),
    .we_i   (cost_we),
    .waddr_i(cost_waddr),
    .wdata_i(cell_cost),
    .raddr_i(cost_raddr),
    .rdata_o(cost_rdata)
  );

  // first row reads the initial row j directly
  assign above = (i_q == LW'(1)) ? j_q : cost_rdata;

  bed_cell #(.CostWidth(LW)) u_cell (
    .a_char_i(first_rdata),
    .b_char_i(second_rdata),
    .diag_i  (diag_q),
    .above_i (above),
    .left_i  (left_q),
    .cost_o  (cell_cost)
  );

  // length rule
  assign gap     = (first_len_q > second_len_q) ? (first_len_q - second_len_q)
                                                : (second_len_q - first_len_q);
  assign len_cut = (first_len_q > LW'(MaxLen)) || (second_len_q > LW'(MaxLen)) ||
                   (gap > LW'(bed_pkg::LenGapLimit));

  // saturate to the output field
  assign res_wide = WW'(res_q);

  // sequencer
  always_comb begin
    state_d      = state_q;
    first_len_d  = first_len_q;
    second_len_d = second_len_q;
    i_d          = i_q;
    j_d          = j_q;
    diag_d       = diag_q;
    left_d       = left_q;
    res_d        = res_q;
    cut_d        = cut_q;
    out_valid_d  = out_valid_q && out_stall_i;
    dist_d       = dist_q;
    cut_out_d    = cut_out_q;
    case (state_q)
      StIdle: begin
        if (in_fire) begin
          if (text_char_i != '0) begin
            if (second_string_i) begin
              second_len_d = (second_len_q < LW'(MaxLen)) ? second_len_q + LW'(1)
                                                          : LW'(MaxLen + 1);
            end else begin
              first_len_d = (first_len_q < LW'(MaxLen)) ? first_len_q + LW'(1)
                                                        : LW'(MaxLen + 1);
            end
          end
          if (pair_done_i) begin
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        cut_d   = len_cut;
        state_d = StDeliver;
        if (len_cut) begin
          res_d = LW'(bed_pkg::CutDistance);
        end else if (first_len_q == '0) begin
          res_d = second_len_q;
        end else if (second_len_q == '0) begin
          res_d = first_len_q;
        end else begin
          i_d     = LW'(1);
          state_d = StRow;
        end
      end
      StRow: begin
        j_d     = LW'(1);
        diag_d  = i_q - LW'(1);
        left_d  = i_q;
        state_d = StCell;
      end
      StCell: begin
        left_d = cell_cost;
        diag_d = above;
        if (last_col) begin
          if (i_q == first_len_q) begin
            res_d   = cell_cost;
            state_d = StDeliver;
          end else begin
            i_d     = i_q + LW'(1);
            state_d = StRow;
          end
        end else begin
          j_d = j_q + LW'(1);
        end
      end
      StDeliver: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          dist_d       = (res_wide > WW'(bed_pkg::DistMax))
                         ? bed_pkg::DistWidth'(bed_pkg::DistMax)
                         : res_wide[bed_pkg::DistWidth-1:0];
          cut_out_d    = cut_q;
          first_len_d  = '0;
          second_len_d = '0;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StIdle;
      first_len_q  <= '0;
      second_len_q <= '0;
      out_valid_q  <= 1'b0;
      i_q          <= '0;
      j_q          <= '0;
    end else begin
      state_q      <= state_d;
      first_len_q  <= first_len_d;
      second_len_q <= second_len_d;
      out_valid_q  <= out_valid_d;
      i_q          <= i_d;
      j_q          <= j_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    diag_q    <= diag_d;
    left_q    <= left_d;
    res_q     <= res_d;
    cut_q     <= cut_d;
    dist_q    <= dist_d;
    cut_out_q <= cut_out_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;
  assign cut_short_o = cut_out_q;

  // checks
  `BED_ASSERT(a_len_bound, clk_i, rst_ni, 1'b1, (first_len_q <= LW'(MaxLen + 1)) && (second_len_q <= LW'(MaxLen + 1)), "string length count beyond saturation")
  `BED_ASSERT(a_col_range, clk_i, rst_ni, state_q == StCell, (j_q != '0) && (j_q <= second_len_q), "column index outside the second string")
  `BED_ASSERT(a_row_range, clk_i, rst_ni, (state_q == StRow) || (state_q == StCell), (i_q != '0) && (i_q <= first_len_q), "row index outside the first string")
  `BED_ASSERT(a_cut_value, clk_i, rst_ni, out_valid_o && cut_short_o, distance_o == bed_pkg::DistWidth'(bed_pkg::CutDistance), "cut result without the cut distance")
  `BED_ASSERT_NEXT(a_done_check, clk_i, rst_ni, in_valid_i && !in_stall_o && pair_done_i, state_q == StCheck, "pair end did not start the length check")

endmodule
